### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the rope constraint block, clocked on clk_i
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked outside reset
`define VRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// property checked on every edge, reset included
`define VRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define VRC_ASSERT(lbl, prop, msg)
`define VRC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/vrc_pkg.sv
// ----------------------------------------------------------------------------
// vrc_pkg
// types, codes and fixed-point helpers of the rope constraint block
// ----------------------------------------------------------------------------
`default_nettype none

package vrc_pkg;

  // command codes of the input channel
  typedef enum logic [1:0] {
    CMD_WR_CIRCLE = 2'd0,
    CMD_WR_LINK   = 2'd1,
    CMD_TICK      = 2'd2,
    CMD_RD_CIRCLE = 2'd3
  } cmd_e;

  // result kinds
  typedef enum logic [1:0] {
    ACK_WRITE = 2'd0,
    ACK_TICK  = 2'd1,
    ACK_READ  = 2'd2
  } ack_e;

  // register indexes of the config port
  typedef enum logic [1:0] {
    REG_FRICTION = 2'd0,
    REG_GRAVITY  = 2'd1,
    REG_PASSES   = 2'd2,
    REG_FLOOR    = 2'd3
  } reg_e;

  localparam int unsigned APB_AW = 4;

  localparam logic [16:0] FRICTION_RST = 17'd64880;
  localparam logic [30:0] GRAVITY_RST  = 31'd642253;
  localparam logic [7:0]  PASSES_RST   = 8'd100;
  localparam logic [15:0] FLOOR_RST    = 16'd1024;

  typedef struct packed {
    logic [16:0] friction;
    logic [30:0] gravity;
    logic [7:0]  passes;
    logic [15:0] floor_y;
  } cfg_t;

  // one circle entry
  typedef struct packed {
    logic               live;
    logic               lock;
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] old_x;
    logic signed [31:0] old_y;
  } circ_t;

  // one link slot
  typedef struct packed {
    logic        used;
    logic [5:0]  high_end;
    logic [5:0]  low_end;
    logic [30:0] len;
  } link_t;

  localparam logic signed [39:0] SAT_MAX = 40'sd2147483647;
  localparam logic signed [39:0] SAT_MIN = -40'sd2147483648;

  // clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // drop 16 fraction bits, rounding toward zero
  function automatic logic signed [33:0] trunc_q16(input logic signed [49:0] p);
    logic signed [49:0] t;
    t = p[49] ? (p + 50'sd65535) : p;
    return t[49:16];
  endfunction

endpackage

`default_nettype wire

### rtl/vrc_cfg.sv
// ----------------------------------------------------------------------------
// vrc_cfg
// apb register file holding friction, gravity, pass count and floor
// ----------------------------------------------------------------------------
`default_nettype none

module vrc_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [vrc_pkg::APB_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output vrc_pkg::cfg_t                    cfg_o
);

  vrc_pkg::cfg_t cfg_q;
  vrc_pkg::reg_e sel;
  logic          wr_en;

  assign sel    = vrc_pkg::reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.friction <= vrc_pkg::FRICTION_RST;
      cfg_q.gravity  <= vrc_pkg::GRAVITY_RST;
      cfg_q.passes   <= vrc_pkg::PASSES_RST;
      cfg_q.floor_y  <= vrc_pkg::FLOOR_RST;
    end else if (wr_en) begin
      unique case (sel)
        vrc_pkg::REG_FRICTION: cfg_q.friction <= pwdata[16:0];
        vrc_pkg::REG_GRAVITY:  cfg_q.gravity  <= pwdata[30:0];
        vrc_pkg::REG_PASSES:   cfg_q.passes   <= pwdata[7:0];
        vrc_pkg::REG_FLOOR:    cfg_q.floor_y  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (sel)
      vrc_pkg::REG_FRICTION: prdata = {15'd0, cfg_q.friction};
      vrc_pkg::REG_GRAVITY:  prdata = {1'b0, cfg_q.gravity};
      vrc_pkg::REG_PASSES:   prdata = {24'd0, cfg_q.passes};
      vrc_pkg::REG_FLOOR:    prdata = {16'd0, cfg_q.floor_y};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/vrc_isqrt.sv
// ----------------------------------------------------------------------------
// vrc_isqrt
// floor square root of a 64 bit value, one root bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module vrc_isqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] radicand_i,
  output logic             done_o,
  output logic [31:0]      root_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [63:0] val_q;
  logic [35:0] rem_q;
  logic [31:0] root_q;
  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        take;

  // bring in the next two radicand bits and try the next root bit
  assign rem_sh = {rem_q[33:0], val_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign take   = (rem_sh >= trial);

  assign done_o = done_q;
  assign root_o = root_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= radicand_i;
      rem_q  <= 36'd0;
      root_q <= 32'd0;
    end else if (busy_q) begin
      val_q <= {val_q[61:0], 2'b00};
      if (take) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

### rtl/vrc_divu.sv
// ----------------------------------------------------------------------------
// vrc_divu
// unsigned 48 by 32 bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module vrc_divu (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [47:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [47:0]      quot_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [47:0] num_q;
  logic [31:0] den_q;
  logic [31:0] rem_q;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic        take;

  // shift in one dividend bit and compare
  assign rem_sh  = {rem_q, num_q[47]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign take    = (rem_sh >= {1'b0, den_q});

  assign done_o = done_q;
  assign quot_o = num_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd47) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient bits replace dividend bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= 32'd0;
    end else if (busy_q) begin
      num_q <= {num_q[46:0], take};
      rem_q <= take ? rem_sub[31:0] : rem_sh[31:0];
    end
  end

endmodule

`default_nettype wire

### rtl/verlet_rope_constraint_step.sv
// ----------------------------------------------------------------------------
// verlet_rope_constraint_step
// circle and link writes are acked in the cycle after the beat; a read goes
//   through ST_RD_RESP, which loads the result from the registered read word
// tick time is set by the serial square root and, for a nonzero root, the two serial
//   divisions per used link, on a circle memory with one read and one write port
// one command in flight at a time; next beat taken once its result is out
// reset: a clearing sweep over all NUM_CIRCLES*LINKS_PER_CIRCLE link slots zeroes
//   both memories, input stalled meanwhile; control registers load reset values
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module verlet_rope_constraint_step #(
  parameter int NUM_CIRCLES      = 64,
  parameter int LINKS_PER_CIRCLE = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // config port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [vrc_pkg::APB_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  // command channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  cmd_i,
  input  wire logic [5:0]                  circle_index_i,
  input  wire logic [1:0]                  link_slot_i,
  input  wire logic signed [31:0]          pos_x_i,
  input  wire logic signed [31:0]          pos_y_i,
  input  wire logic                        locked_i,
  input  wire logic                        active_i,
  input  wire logic                        link_valid_i,
  input  wire logic [5:0]                  link_left_i,
  input  wire logic [5:0]                  link_right_i,
  input  wire logic [30:0]                 link_length_i,
  input  wire logic [19:0]                 tick_dt_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       ack_kind_o,
  output logic                             out_active_o,
  output logic                             out_locked_o,
  output logic signed [31:0]               out_x_o,
  output logic signed [31:0]               out_y_o
);

  localparam int NUM_LINKS = NUM_CIRCLES * LINKS_PER_CIRCLE;
  localparam int CW        = $clog2(NUM_CIRCLES);
  localparam int LW        = $clog2(NUM_LINKS);
  localparam int SW        = (LINKS_PER_CIRCLE > 1) ? $clog2(LINKS_PER_CIRCLE) : 1;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_RD_RESP, ST_G1, ST_G2,
    ST_I_RD, ST_I_VEL, ST_I_MUL, ST_I_WR,
    ST_R_RD, ST_R_CHK, ST_R_RDB, ST_R_GEO, ST_R_SQ0, ST_R_SQ1, ST_R_SQW,
    ST_R_DVX, ST_R_DVY, ST_R_OFF, ST_R_WRA, ST_R_WRB,
    ST_D_RD, ST_D_CHK, ST_D_LK, ST_DONE
  } state_e;

  // config registers
  vrc_pkg::cfg_t cfg;

  vrc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // memories
  vrc_pkg::circ_t circ_mem [NUM_CIRCLES];
  vrc_pkg::link_t link_mem [NUM_LINKS];

  logic           circ_we;
  logic [CW-1:0]  circ_waddr, circ_raddr;
  vrc_pkg::circ_t circ_wdata, circ_rdata_q;
  logic           link_we;
  logic [LW-1:0]  link_waddr, link_raddr;
  vrc_pkg::link_t link_wdata, link_rdata_q;

  always_ff @(posedge clk_i) begin
    if (circ_we) begin
      circ_mem[circ_waddr] <= circ_wdata;
    end
    circ_rdata_q <= circ_mem[circ_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rdata_q <= link_mem[link_raddr];
  end

  // arithmetic units
  logic        sqrt_start, sqrt_done;
  logic [63:0] sqrt_arg;
  logic [31:0] sqrt_root;
  logic        div_start, div_done;
  logic [47:0] div_num, div_quot;
  logic [31:0] div_den;

  vrc_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sqrt_arg),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  vrc_divu u_divu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // control registers
  state_e        state_q, state_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [CW-1:0] ci_q, ci_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [7:0]    pass_q, pass_d;
  logic          rd_ok_q, rd_ok_d;
  logic          out_valid_q;
  logic [1:0]    out_ack_q;
  logic          out_active_q, out_locked_q;
  logic signed [31:0] out_x_q, out_y_q;
  logic          out_load;
  logic [1:0]    out_ack_d;
  logic          out_active_d, out_locked_d;
  logic signed [31:0] out_x_d, out_y_d;

  // datapath registers
  logic [19:0]        dt_q, dt_d;
  logic [50:0]        gp1_q, gp1_d;
  logic [51:0]        gp2_q, gp2_d;
  vrc_pkg::circ_t     wa_q, wa_d, wb_q, wb_d;
  logic signed [31:0] vx_q, vx_d, vy_q, vy_d;
  logic signed [49:0] px_q, px_d, py_q, py_d;
  logic [CW-1:0]      lo_q, lo_d, hi_q, hi_d;
  logic [29:0]        half_q, half_d;
  logic signed [31:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [31:0] dx_q, dx_d, dy_q, dy_d;
  logic [63:0]        sqx_q, sqx_d, sqy_q, sqy_d;
  logic [31:0]        m_q, m_d;
  logic [16:0]        uxm_q, uxm_d, uym_q, uym_d;
  logic [30:0]        offx_q, offx_d, offy_q, offy_d;

  // helper values
  logic               accept;
  vrc_pkg::cmd_e      cmd;
  logic               ci_in_range, slot_in_range, hi_in_range;
  logic [35:0]        g_add;
  logic signed [32:0] sum_x, sum_y, dif_x, dif_y;
  logic signed [63:0] sqx_full, sqy_full;
  logic [31:0]        dxm, dym;
  logic [46:0]        offx_full, offy_full;
  logic signed [39:0] ox, oy;
  logic signed [32:0] floor_q16, y_ext;

  assign accept        = in_valid_i && !in_stall_o;
  assign cmd           = vrc_pkg::cmd_e'(cmd_i);
  assign ci_in_range   = (32'(circle_index_i) < NUM_CIRCLES);
  assign slot_in_range = (32'(link_slot_i) < LINKS_PER_CIRCLE);
  assign hi_in_range   = (32'(link_rdata_q.high_end) < NUM_CIRCLES);
  assign g_add         = gp2_q[51:16];

  // link geometry from the two endpoint words
  assign sum_x = 33'(wa_q.cur_x) + 33'(circ_rdata_q.cur_x);
  assign sum_y = 33'(wa_q.cur_y) + 33'(circ_rdata_q.cur_y);
  assign dif_x = 33'(wa_q.cur_x) - 33'(circ_rdata_q.cur_x);
  assign dif_y = 33'(wa_q.cur_y) - 33'(circ_rdata_q.cur_y);
  assign sqx_full = dx_q * dx_q;
  assign sqy_full = dy_q * dy_q;
  assign dxm = dx_q[31] ? (32'd0 - dx_q) : dx_q;
  assign dym = dy_q[31] ? (32'd0 - dy_q) : dy_q;
  assign offx_full = uxm_q * half_q;
  assign offy_full = uym_q * half_q;
  assign ox = dx_q[31] ? -$signed({9'd0, offx_q}) : $signed({9'd0, offx_q});
  assign oy = dy_q[31] ? -$signed({9'd0, offy_q}) : $signed({9'd0, offy_q});

  // floor test
  assign floor_q16 = $signed({1'b0, cfg.floor_y, 16'd0});
  assign y_ext     = 33'(circ_rdata_q.cur_y);

  // the x division starts on the root's done pulse, before m_q holds it
  assign sqrt_arg = sqx_q + sqy_q;
  assign div_den  = (state_q == ST_R_SQW) ? sqrt_root : m_q;
  assign div_num  = (state_q == ST_R_SQW) ? {dxm, 16'd0} : {dym, 16'd0};

  // sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    ci_d    = ci_q;
    slot_d  = slot_q;
    pass_d  = pass_q;
    rd_ok_d = rd_ok_q;
    dt_d    = dt_q;
    gp1_d   = gp1_q;
    gp2_d   = gp2_q;
    wa_d    = wa_q;
    wb_d    = wb_q;
    vx_d    = vx_q;
    vy_d    = vy_q;
    px_d    = px_q;
    py_d    = py_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    half_d  = half_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    sqx_d   = sqx_q;
    sqy_d   = sqy_q;
    m_d     = m_q;
    uxm_d   = uxm_q;
    uym_d   = uym_q;
    offx_d  = offx_q;
    offy_d  = offy_q;

    circ_we    = 1'b0;
    circ_waddr = ci_q;
    circ_wdata = '0;
    circ_raddr = ci_q;
    link_we    = 1'b0;
    link_waddr = idx_q;
    link_wdata = '0;
    link_raddr = idx_q;
    sqrt_start = 1'b0;
    div_start  = 1'b0;

    out_load     = 1'b0;
    out_ack_d    = vrc_pkg::ACK_WRITE;
    out_active_d = 1'b0;
    out_locked_d = 1'b0;
    out_x_d      = '0;
    out_y_d      = '0;

    unique case (state_q)
      // zero both memories after reset
      ST_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = idx_q;
        circ_we    = (32'(idx_q) < NUM_CIRCLES);
        circ_waddr = CW'(idx_q);
        if (idx_q == LW'(NUM_LINKS - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            vrc_pkg::CMD_WR_CIRCLE: begin
              circ_we    = ci_in_range;
              circ_waddr = CW'(circle_index_i);
              circ_wdata = '{live: active_i, lock: locked_i, cur_x: pos_x_i,
                             cur_y: pos_y_i, old_x: pos_x_i, old_y: pos_y_i};
              out_load   = 1'b1;
            end
            vrc_pkg::CMD_WR_LINK: begin
              link_we    = ci_in_range && slot_in_range;
              link_waddr = LW'(32'(circle_index_i) * LINKS_PER_CIRCLE + 32'(link_slot_i));
              link_wdata = '{used: link_valid_i, high_end: link_left_i,
                             low_end: link_right_i, len: link_length_i};
              out_load   = 1'b1;
            end
            vrc_pkg::CMD_TICK: begin
              dt_d    = tick_dt_i;
              state_d = ST_G1;
            end
            vrc_pkg::CMD_RD_CIRCLE: begin
              circ_raddr = CW'(circle_index_i);
              rd_ok_d    = ci_in_range;
              state_d    = ST_RD_RESP;
            end
            default: ;
          endcase
        end
      end

      ST_RD_RESP: begin
        out_load  = 1'b1;
        out_ack_d = vrc_pkg::ACK_READ;
        if (rd_ok_q) begin
          out_active_d = circ_rdata_q.live;
          out_locked_d = circ_rdata_q.lock;
          out_x_d      = circ_rdata_q.cur_x;
          out_y_d      = circ_rdata_q.cur_y;
        end
        state_d = ST_IDLE;
      end

      // gravity step term, two registered products
      ST_G1: begin
        gp1_d   = cfg.gravity * dt_q;
        state_d = ST_G2;
      end
      ST_G2: begin
        gp2_d   = gp1_q[50:16] * cfg.friction;
        ci_d    = '0;
        state_d = ST_I_RD;
      end

      // integration, one circle at a time
      ST_I_RD: begin
        circ_raddr = ci_q;
        state_d    = ST_I_VEL;
      end
      ST_I_VEL: begin
        wa_d = circ_rdata_q;
        vx_d = vrc_pkg::sat32(40'(circ_rdata_q.cur_x) - 40'(circ_rdata_q.old_x));
        vy_d = vrc_pkg::sat32(40'(circ_rdata_q.cur_y) - 40'(circ_rdata_q.old_y));
        if (circ_rdata_q.live && !circ_rdata_q.lock) begin
          state_d = ST_I_MUL;
        end else if (ci_q == CW'(NUM_CIRCLES - 1)) begin
          ci_d    = '0;
          idx_d   = '0;
          pass_d  = '0;
          state_d = (cfg.passes != 8'd0) ? ST_R_RD : ST_D_RD;
        end else begin
          ci_d    = ci_q + 1'b1;
          state_d = ST_I_RD;
        end
      end
      ST_I_MUL: begin
        px_d    = vx_q * $signed({1'b0, cfg.friction});
        py_d    = vy_q * $signed({1'b0, cfg.friction});
        state_d = ST_I_WR;
      end
      ST_I_WR: begin
        circ_we          = 1'b1;
        circ_waddr       = ci_q;
        circ_wdata       = wa_q;
        circ_wdata.old_x = wa_q.cur_x;
        circ_wdata.old_y = wa_q.cur_y;
        circ_wdata.cur_x = vrc_pkg::sat32(40'(wa_q.cur_x) + 40'(vrc_pkg::trunc_q16(px_q)));
        circ_wdata.cur_y = vrc_pkg::sat32(40'(wa_q.cur_y) + 40'(vrc_pkg::trunc_q16(py_q))
                                          + $signed({4'd0, g_add}));
        if (ci_q == CW'(NUM_CIRCLES - 1)) begin
          ci_d    = '0;
          idx_d   = '0;
          pass_d  = '0;
          state_d = (cfg.passes != 8'd0) ? ST_R_RD : ST_D_RD;
        end else begin
          ci_d    = ci_q + 1'b1;
          state_d = ST_I_RD;
        end
      end

      // relaxation, one link slot at a time
      ST_R_RD: begin
        link_raddr = idx_q;
        state_d    = ST_R_CHK;
      end
      ST_R_CHK: begin
        lo_d   = CW'(link_rdata_q.low_end);
        hi_d   = CW'(link_rdata_q.high_end);
        half_d = link_rdata_q.len[30:1];
        circ_raddr = CW'(link_rdata_q.low_end);
        if (link_rdata_q.used && (link_rdata_q.low_end < link_rdata_q.high_end)
            && hi_in_range) begin
          state_d = ST_R_RDB;
        end else if (idx_q == LW'(NUM_LINKS - 1)) begin
          idx_d = '0;
          if (pass_q == cfg.passes - 8'd1) begin
            ci_d    = '0;
            state_d = ST_D_RD;
          end else begin
            pass_d  = pass_q + 8'd1;
            state_d = ST_R_RD;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_R_RD;
        end
      end
      ST_R_RDB: begin
        wa_d       = circ_rdata_q;
        circ_raddr = hi_q;
        state_d    = ST_R_GEO;
      end
      ST_R_GEO: begin
        wb_d    = circ_rdata_q;
        cx_d    = 32'((sum_x + 33'(sum_x[32])) >>> 1);
        cy_d    = 32'((sum_y + 33'(sum_y[32])) >>> 1);
        dx_d    = vrc_pkg::sat32(40'(dif_x));
        dy_d    = vrc_pkg::sat32(40'(dif_y));
        state_d = ST_R_SQ0;
      end
      ST_R_SQ0: begin
        sqx_d   = sqx_full;
        sqy_d   = sqy_full;
        state_d = ST_R_SQ1;
      end
      ST_R_SQ1: begin
        sqrt_start = 1'b1;
        state_d    = ST_R_SQW;
      end
      ST_R_SQW: begin
        if (sqrt_done) begin
          m_d = sqrt_root;
          if (sqrt_root == 32'd0) begin
            uxm_d   = '0;
            uym_d   = '0;
            state_d = ST_R_OFF;
          end else begin
            state_d = ST_R_DVX;
          end
        end
      end
      ST_R_DVX: begin
        if (div_done) begin
          uxm_d   = div_quot[16:0];
          state_d = ST_R_DVY;
        end
      end
      ST_R_DVY: begin
        if (div_done) begin
          uym_d   = div_quot[16:0];
          state_d = ST_R_OFF;
        end
      end
      ST_R_OFF: begin
        offx_d  = offx_full[46:16];
        offy_d  = offy_full[46:16];
        state_d = ST_R_WRA;
      end
      ST_R_WRA: begin
        circ_we          = !wa_q.lock;
        circ_waddr       = lo_q;
        circ_wdata       = wa_q;
        circ_wdata.cur_x = vrc_pkg::sat32(40'(cx_q) + ox);
        circ_wdata.cur_y = vrc_pkg::sat32(40'(cy_q) + oy);
        state_d          = ST_R_WRB;
      end
      ST_R_WRB: begin
        circ_we          = !wb_q.lock;
        circ_waddr       = hi_q;
        circ_wdata       = wb_q;
        circ_wdata.cur_x = vrc_pkg::sat32(40'(cx_q) - ox);
        circ_wdata.cur_y = vrc_pkg::sat32(40'(cy_q) - oy);
        if (idx_q == LW'(NUM_LINKS - 1)) begin
          idx_d = '0;
          if (pass_q == cfg.passes - 8'd1) begin
            ci_d    = '0;
            state_d = ST_D_RD;
          end else begin
            pass_d  = pass_q + 8'd1;
            state_d = ST_R_RD;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_R_RD;
        end
      end

      // removal of circles below the floor
      ST_D_RD: begin
        circ_raddr = ci_q;
        state_d    = ST_D_CHK;
      end
      ST_D_CHK: begin
        slot_d = '0;
        if (circ_rdata_q.live && (y_ext > floor_q16)) begin
          circ_we    = 1'b1;
          circ_waddr = ci_q;
          state_d    = ST_D_LK;
        end else if (ci_q == CW'(NUM_CIRCLES - 1)) begin
          state_d = ST_DONE;
        end else begin
          ci_d    = ci_q + 1'b1;
          state_d = ST_D_RD;
        end
      end
      ST_D_LK: begin
        link_we    = 1'b1;
        link_waddr = LW'(32'(ci_q) * LINKS_PER_CIRCLE + 32'(slot_q));
        if (slot_q == SW'(LINKS_PER_CIRCLE - 1)) begin
          if (ci_q == CW'(NUM_CIRCLES - 1)) begin
            state_d = ST_DONE;
          end else begin
            ci_d    = ci_q + 1'b1;
            state_d = ST_D_RD;
          end
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end

      ST_DONE: begin
        out_load  = 1'b1;
        out_ack_d = vrc_pkg::ACK_TICK;
        state_d   = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase

    // division launches: x after the root, y after the x quotient
    if ((state_q == ST_R_SQW) && sqrt_done && (sqrt_root != 32'd0)) begin
      div_start = 1'b1;
    end
    if ((state_q == ST_R_DVX) && div_done) begin
      div_start = 1'b1;
    end
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      idx_q        <= '0;
      ci_q         <= '0;
      slot_q       <= '0;
      pass_q       <= '0;
      rd_ok_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      out_ack_q    <= vrc_pkg::ACK_WRITE;
      out_active_q <= 1'b0;
      out_locked_q <= 1'b0;
      out_x_q      <= '0;
      out_y_q      <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ci_q    <= ci_d;
      slot_q  <= slot_d;
      pass_q  <= pass_d;
      rd_ok_q <= rd_ok_d;
      if (out_load) begin
        out_valid_q  <= 1'b1;
        out_ack_q    <= out_ack_d;
        out_active_q <= out_active_d;
        out_locked_q <= out_locked_d;
        out_x_q      <= out_x_d;
        out_y_q      <= out_y_d;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dt_q   <= dt_d;
    gp1_q  <= gp1_d;
    gp2_q  <= gp2_d;
    wa_q   <= wa_d;
    wb_q   <= wb_d;
    vx_q   <= vx_d;
    vy_q   <= vy_d;
    px_q   <= px_d;
    py_q   <= py_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    half_q <= half_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    sqx_q  <= sqx_d;
    sqy_q  <= sqy_d;
    m_q    <= m_d;
    uxm_q  <= uxm_d;
    uym_q  <= uym_d;
    offx_q <= offx_d;
    offy_q <= offy_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign out_valid_o  = out_valid_q;
  assign ack_kind_o   = out_ack_q;
  assign out_active_o = out_active_q;
  assign out_locked_o = out_locked_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;

  // checks
  `VRC_ASSERT(a_clear_stalls, (state_q == ST_CLEAR) |-> in_stall_o, "beat taken during clear sweep")
  `VRC_ASSERT_ALWAYS(a_clear_no_out, (state_q == ST_CLEAR) |-> !out_valid_q, "result during clear sweep")
  `VRC_ASSERT(a_unit_vec, (div_done && (state_q == ST_R_DVX || state_q == ST_R_DVY)) |-> (div_quot <= 48'd65536), "unit direction exceeds one")
  `VRC_ASSERT(a_link_ends, (state_q == ST_R_WRB) |-> (lo_q != hi_q), "link endpoints coincide")

endmodule

`default_nettype wire
